// ===== sv/fthgu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fthgu_pkg - shared types and constants of the history gravity update block
// Field widths, register indexes, reset values and state codes.
// ----------------------------------------------------------------------------
package fthgu_pkg;

    localparam int MODE_W     = 2;
    localparam int SQ_FIELD_W = 6;
    localparam int BONUS_W    = 17;
    localparam int SCORE_W    = 18;
    localparam int FILL_W     = 14;
    localparam int MAXB_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int MAG_W      = 18;
    localparam int PROD_W     = 34;
    localparam int SUM_W      = 36;
    localparam int CNT_W      = 5;

    localparam int MUL_STEPS  = 9;
    localparam int DIV_STEPS  = 17;

    localparam logic [FILL_W-1:0] FILL_RESET      = 14'sd2;
    localparam logic [MAXB_W-1:0] MAX_BONUS_RESET = 16'd9856;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 18'sh1FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 18'sh20000;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BONUS  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_DONE
    } t_state;

endpackage

// ===== sv/from_to_history_gravity_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// from_to_history_gravity_update - history score table with gravity update
// Flow: lookup passes the read, exec and done states; update adds 9 radix-4
// multiply steps and 17 radix-4 divide steps (skipped with a zero divisor) and
// a sum state; clear sweeps SIDES*SQUARES*SQUARES entries, one table entry
// written per cycle. A held result adds its stall. One item in flight.
// Reset: synchronous active low; a clearing pass then writes 2 to every entry
// while input is held off.
// ----------------------------------------------------------------------------
module from_to_history_gravity_update #(
    parameter int SQUARES = 64,
    parameter int SIDES   = 2
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [fthgu_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [fthgu_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [fthgu_pkg::MODE_W-1:0]            i_mode,
    input  logic                                    i_side,
    input  logic [fthgu_pkg::SQ_FIELD_W-1:0]        i_from_square,
    input  logic [fthgu_pkg::SQ_FIELD_W-1:0]        i_to_square,
    input  logic signed [fthgu_pkg::BONUS_W-1:0]    i_bonus,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [fthgu_pkg::SCORE_W-1:0]    o_score
);

    localparam int DEPTH = SIDES * SQUARES * SQUARES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(SQUARES * SQUARES);
    localparam logic [AW-1:0] COL_STRIDE = AW'(SQUARES);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [8:0]    SQ_LIM     = 9'(SQUARES);

    localparam int SW = fthgu_pkg::SCORE_W;
    localparam int PW = fthgu_pkg::PROD_W;
    localparam int MW = fthgu_pkg::MAXB_W;
    localparam int XW = fthgu_pkg::SUM_W;

    fthgu_pkg::t_state r_state, n_state;
    fthgu_pkg::t_mode  r_mode;

    logic signed [fthgu_pkg::FILL_W-1:0] r_fill;
    logic [MW-1:0]                       r_max_bonus;

    logic [SW-1:0]  r_table [DEPTH];
    logic [SW-1:0]  r_rdata;
    logic [AW-1:0]  r_addr;
    logic [AW-1:0]  r_sweep_addr;
    logic [SW-1:0]  r_sweep_val;
    logic           r_sweep_reply;

    logic signed [fthgu_pkg::BONUS_W-1:0] r_bonus;
    logic signed [SW-1:0]                 r_h;
    logic [fthgu_pkg::MAG_W-1:0]          r_mag;
    logic [PW-1:0]                        r_mcand;
    logic [PW-1:0]                        r_num;
    logic [MW-1:0]                        r_rem;
    logic [fthgu_pkg::CNT_W-1:0]          r_cnt;
    logic signed [SW-1:0]                 r_result;
    logic                                 r_out_valid;
    logic signed [SW-1:0]                 r_score;

    logic           accept;
    logic           out_load;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [SW-1:0]  mem_wdata;
    logic [8:0]     from_mod, to_mod;
    logic [AW-1:0]  in_addr;
    logic           side_mod;

    logic [MW:0]    t1, t2;
    logic           ge1, ge2;
    logic [MW-1:0]  rem1, rem2;
    logic [PW-1:0]  mul_add;

    logic signed [XW-1:0] grav, sum;
    logic signed [SW-1:0] sat;
    logic [SW-1:0]        h_abs;
    logic [fthgu_pkg::BONUS_W-1:0] b_abs;

    // coordinate reduction and table address
    always_comb begin
        from_mod = {3'b000, i_from_square};
        to_mod   = {3'b000, i_to_square};
        for (int k = 0; k < 4; k++) begin
            if (from_mod >= SQ_LIM) begin
                from_mod = from_mod - SQ_LIM;
            end
            if (to_mod >= SQ_LIM) begin
                to_mod = to_mod - SQ_LIM;
            end
        end
        side_mod = (SIDES > 1) ? i_side : 1'b0;
        in_addr  = AW'(side_mod) * ROW_STRIDE + AW'(from_mod) * COL_STRIDE + AW'(to_mod);
    end

    // radix-4 multiply and divide digits
    always_comb begin
        mul_add = (r_mag[0] ? r_mcand : '0) + (r_mag[1] ? {r_mcand[PW-2:0], 1'b0} : '0);
        t1   = {r_rem, r_num[PW-1]};
        ge1  = t1 >= {1'b0, r_max_bonus};
        rem1 = ge1 ? MW'(t1 - {1'b0, r_max_bonus}) : t1[MW-1:0];
        t2   = {rem1, r_num[PW-2]};
        ge2  = t2 >= {1'b0, r_max_bonus};
        rem2 = ge2 ? MW'(t2 - {1'b0, r_max_bonus}) : t2[MW-1:0];
    end

    // final sum and saturation
    always_comb begin
        grav = r_h[SW-1] ? -$signed({2'b00, r_num}) : $signed({2'b00, r_num});
        sum  = XW'(r_h) + XW'(r_bonus) - grav;
        if (sum > XW'(fthgu_pkg::SCORE_MAX)) begin
            sat = fthgu_pkg::SCORE_MAX;
        end else if (sum < XW'(fthgu_pkg::SCORE_MIN)) begin
            sat = fthgu_pkg::SCORE_MIN;
        end else begin
            sat = SW'(sum);
        end
        h_abs = r_rdata[SW-1] ? SW'(-$signed(r_rdata)) : r_rdata;
        b_abs = r_bonus[fthgu_pkg::BONUS_W-1] ? fthgu_pkg::BONUS_W'(-r_bonus) : r_bonus;
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fthgu_pkg::ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = sat;
        unique case (r_state)
            fthgu_pkg::ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_waddr = r_sweep_addr;
                mem_wdata = r_sweep_val;
                if (r_sweep_addr == LAST_ADDR) begin
                    n_state = r_sweep_reply ? fthgu_pkg::ST_DONE : fthgu_pkg::ST_IDLE;
                end
            end
            fthgu_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = fthgu_pkg::ST_READ;
                end
            end
            fthgu_pkg::ST_READ: begin
                n_state = fthgu_pkg::ST_EXEC;
            end
            fthgu_pkg::ST_EXEC: begin
                unique case (r_mode)
                    fthgu_pkg::MODE_UPDATE: n_state = fthgu_pkg::ST_MUL;
                    fthgu_pkg::MODE_CLEAR:  n_state = fthgu_pkg::ST_SWEEP;
                    default:                n_state = fthgu_pkg::ST_DONE;
                endcase
            end
            fthgu_pkg::ST_MUL: begin
                if (r_cnt == fthgu_pkg::CNT_W'(fthgu_pkg::MUL_STEPS - 1)) begin
                    n_state = (r_max_bonus == '0) ? fthgu_pkg::ST_SUM : fthgu_pkg::ST_DIV;
                end
            end
            fthgu_pkg::ST_DIV: begin
                if (r_cnt == fthgu_pkg::CNT_W'(fthgu_pkg::DIV_STEPS - 1)) begin
                    n_state = fthgu_pkg::ST_SUM;
                end
            end
            fthgu_pkg::ST_SUM: begin
                mem_we  = 1'b1;
                n_state = fthgu_pkg::ST_DONE;
            end
            fthgu_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = fthgu_pkg::ST_IDLE;
                end
            end
            default: n_state = fthgu_pkg::ST_IDLE;
        endcase
    end

    assign accept = o_in_ready && i_in_valid;

    // table storage
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_table[r_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= fthgu_pkg::FILL_RESET;
            r_max_bonus <= fthgu_pkg::MAX_BONUS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fthgu_pkg::CFG_FILL_VALUE: r_fill      <= i_cfg_data[fthgu_pkg::FILL_W-1:0];
                fthgu_pkg::CFG_MAX_BONUS:  r_max_bonus <= i_cfg_data[MW-1:0];
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr  <= '0;
            r_sweep_val   <= SW'(fthgu_pkg::FILL_RESET);
            r_sweep_reply <= 1'b0;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_mode        <= fthgu_pkg::MODE_LOOKUP;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == fthgu_pkg::ST_SWEEP) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
            end
            if (r_state == fthgu_pkg::ST_MUL || r_state == fthgu_pkg::ST_DIV) begin
                r_cnt <= (n_state == r_state) ? r_cnt + fthgu_pkg::CNT_W'(1) : '0;
            end
            if (accept) begin
                unique case (i_mode)
                    fthgu_pkg::MODE_UPDATE: r_mode <= fthgu_pkg::MODE_UPDATE;
                    fthgu_pkg::MODE_CLEAR:  r_mode <= fthgu_pkg::MODE_CLEAR;
                    default:                r_mode <= fthgu_pkg::MODE_LOOKUP;
                endcase
            end
            if (r_state == fthgu_pkg::ST_EXEC && r_mode == fthgu_pkg::MODE_CLEAR) begin
                r_sweep_addr  <= '0;
                r_sweep_val   <= SW'(r_fill);
                r_sweep_reply <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr  <= in_addr;
            r_bonus <= i_bonus;
        end
        case (r_state)
            fthgu_pkg::ST_EXEC: begin
                r_h     <= r_rdata;
                r_mcand <= PW'(h_abs);
                r_mag   <= fthgu_pkg::MAG_W'(b_abs);
                r_num   <= '0;
                r_rem   <= '0;
                if (r_mode == fthgu_pkg::MODE_CLEAR) begin
                    r_result <= SW'(r_fill);
                end else begin
                    r_result <= r_rdata;
                end
            end
            fthgu_pkg::ST_MUL: begin
                r_num   <= (n_state == fthgu_pkg::ST_SUM) ? '0 : r_num + mul_add;
                r_mcand <= {r_mcand[PW-3:0], 2'b00};
                r_mag   <= {2'b00, r_mag[fthgu_pkg::MAG_W-1:2]};
            end
            fthgu_pkg::ST_DIV: begin
                r_num <= {r_num[PW-3:0], ge1, ge2};
                r_rem <= rem2;
            end
            fthgu_pkg::ST_SUM: begin
                r_result <= sat;
            end
            default: ;
        endcase
        if (out_load) begin
            r_score <= r_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;

endmodule

// ===== tb/from_to_history_gravity_update_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// from_to_history_gravity_update_test - self-checking bench for the history
// score table with gravity update
// Drives lookup, update and clear beats over valid/ready with random gaps and
// one long output stall. Reprograms fill value and divisor between phases,
// including their extremes and a zero divisor. Every returned score is checked
// against a cycle-free copy of the table kept in a scoreboard class.
// ----------------------------------------------------------------------------
module from_to_history_gravity_update_test;

    localparam int SQUARES        = 64;
    localparam int SIDES          = 2;
    localparam int TABLE_DEPTH    = SIDES * SQUARES * SQUARES;
    localparam int PHASE_ITEMS    = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam logic [fthgu_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    class score_tracker;
        int                                       score_table [TABLE_DEPTH];
        logic signed [fthgu_pkg::FILL_W-1:0]      fill_value;
        logic        [fthgu_pkg::MAXB_W-1:0]      max_bonus;
        logic signed [fthgu_pkg::SCORE_W-1:0]     pending_scores [$];

        function new();
            fill_value = fthgu_pkg::FILL_RESET;
            max_bonus  = fthgu_pkg::MAX_BONUS_RESET;
            fill_table();
        endfunction

        function void fill_table();
            foreach (score_table[i]) score_table[i] = fill_value;
        endfunction

        function void set_register(logic [fthgu_pkg::CFG_IDX_W-1:0] idx,
                                   logic [fthgu_pkg::CFG_DATA_W-1:0] data);
            if (idx == fthgu_pkg::CFG_FILL_VALUE) begin
                fill_value = data[fthgu_pkg::FILL_W-1:0];
            end else begin
                max_bonus = data[fthgu_pkg::MAXB_W-1:0];
            end
        endfunction

        function int pending();
            return pending_scores.size();
        endfunction

        // Accepted input beat: apply it to the table copy, queue the score.
        function void note_item(logic [fthgu_pkg::MODE_W-1:0] mode, logic side,
                                logic [fthgu_pkg::SQ_FIELD_W-1:0] from_sq,
                                logic [fthgu_pkg::SQ_FIELD_W-1:0] to_sq,
                                logic signed [fthgu_pkg::BONUS_W-1:0] bonus);
            int unsigned                          idx;
            longint                               h;
            longint                               mag;
            longint                               grav;
            longint                               updated;
            logic signed [fthgu_pkg::SCORE_W-1:0] fill_ext;
            idx = (side % SIDES) * SQUARES * SQUARES + (from_sq % SQUARES) * SQUARES
                + (to_sq % SQUARES);
            case (mode)
                fthgu_pkg::MODE_CLEAR: begin
                    fill_table();
                    fill_ext = fill_value;
                    pending_scores.push_back(fill_ext);
                end
                fthgu_pkg::MODE_UPDATE: begin
                    h    = score_table[idx];
                    mag  = (bonus < 0) ? -longint'(bonus) : longint'(bonus);
                    grav = 0;
                    if (max_bonus != 0) grav = (h * mag) / longint'({48'd0, max_bonus});
                    updated = h + longint'(bonus) - grav;
                    if (updated > fthgu_pkg::SCORE_MAX) updated = fthgu_pkg::SCORE_MAX;
                    if (updated < fthgu_pkg::SCORE_MIN) updated = fthgu_pkg::SCORE_MIN;
                    score_table[idx] = int'(updated);
                    pending_scores.push_back(fthgu_pkg::SCORE_W'(updated));
                end
                default: begin
                    pending_scores.push_back(fthgu_pkg::SCORE_W'(score_table[idx]));
                end
            endcase
        endfunction

        function string check_score(logic signed [fthgu_pkg::SCORE_W-1:0] got);
            logic signed [fthgu_pkg::SCORE_W-1:0] want;
            if (pending_scores.size() == 0)
                return $sformatf("score %0d returned with nothing outstanding", got);
            want = pending_scores.pop_front();
            if (got !== want)
                return $sformatf("score got %0d expected %0d", got, want);
            return "";
        endfunction
    endclass

    logic                                    i_clk         = 1'b0;
    logic                                    i_rst_n       = 1'b0;
    logic                                    i_cfg_we      = 1'b0;
    logic [fthgu_pkg::CFG_IDX_W-1:0]         i_cfg_index   = '0;
    logic [fthgu_pkg::CFG_DATA_W-1:0]        i_cfg_data    = '0;
    logic                                    i_in_valid    = 1'b0;
    logic                                    o_in_ready;
    logic [fthgu_pkg::MODE_W-1:0]            i_mode        = '0;
    logic                                    i_side        = 1'b0;
    logic [fthgu_pkg::SQ_FIELD_W-1:0]        i_from_square = '0;
    logic [fthgu_pkg::SQ_FIELD_W-1:0]        i_to_square   = '0;
    logic signed [fthgu_pkg::BONUS_W-1:0]    i_bonus       = '0;
    logic                                    o_out_valid;
    logic                                    i_out_ready   = 1'b0;
    logic signed [fthgu_pkg::SCORE_W-1:0]    o_score;

    score_tracker tracker = new();
    int           mismatches   = 0;
    int           stall_left   = 0;
    int           quiet_cycles = 0;
    bit           no_gaps      = 1'b0;
    bit           hold_pending = 1'b0;

    from_to_history_gravity_update #(
        .SQUARES (SQUARES),
        .SIDES   (SIDES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_side        (i_side),
        .i_from_square (i_from_square),
        .i_to_square   (i_to_square),
        .i_bonus       (i_bonus),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_score       (o_score)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    task automatic send_item(input logic [fthgu_pkg::MODE_W-1:0] mode, input logic side,
                             input logic [fthgu_pkg::SQ_FIELD_W-1:0] from_sq,
                             input logic [fthgu_pkg::SQ_FIELD_W-1:0] to_sq,
                             input logic signed [fthgu_pkg::BONUS_W-1:0] bonus);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_side        <= side;
        i_from_square <= from_sq;
        i_to_square   <= to_sq;
        i_bonus       <= bonus;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_item(mode, side, from_sq, to_sq, bonus);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_register(input logic [fthgu_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [fthgu_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        tracker.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // bits above the fill field are don't-care, so they get random values
    task automatic configure(input int fill, input int divisor);
        write_register(fthgu_pkg::CFG_FILL_VALUE,
                       {(fthgu_pkg::CFG_DATA_W-fthgu_pkg::FILL_W)'($urandom_range(0, 3)),
                        fthgu_pkg::FILL_W'(fill)});
        write_register(fthgu_pkg::CFG_MAX_BONUS, fthgu_pkg::MAXB_W'(divisor));
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : score_sink
        string msg;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            msg = tracker.check_score(o_score);
            if (msg != "") report_mismatch(msg);
            if (hold_pending) begin
                stall_left   = HOLD_CYCLES;
                hold_pending = 1'b0;
            end else begin
                stall_left = no_gaps ? 0 : $urandom_range(0, 5);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int                            fill_list [6];
        int                            divisor_list [6];
        logic [12:0]                   hot [8];
        logic [12:0]                   entry;
        logic [fthgu_pkg::MODE_W-1:0]  mode;
        int                            pick;
        int                            bonus_val;

        fill_list    = '{-5000, 5000, -8192, 8191, 0, 2};
        divisor_list = '{1, 50000, 65535, 0, 0, 9856};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // reset starts a clearing pass; wait it out
        do @(posedge i_clk); while (!o_in_ready);

        send_item(fthgu_pkg::MODE_LOOKUP, 1'b0, 6'd0, 6'd0, 17'sd0);
        send_item(fthgu_pkg::MODE_LOOKUP, 1'b1, 6'd63, 6'd63, 17'sd0);
        send_item(fthgu_pkg::MODE_UPDATE, 1'b1, 6'd63, 6'd63, 17'sd50000);
        send_item(fthgu_pkg::MODE_UPDATE, 1'b1, 6'd63, 6'd63, -17'sd50000);
        send_item(fthgu_pkg::MODE_UPDATE, 1'b0, 6'd0, 6'd0, -17'sd65536);
        send_item(fthgu_pkg::MODE_UPDATE, 1'b0, 6'd0, 6'd0, 17'sd65535);
        send_item(MODE_SPARE, 1'b1, 6'd63, 6'd63, -17'sd1);
        send_item(fthgu_pkg::MODE_UPDATE, 1'b0, 6'd63, 6'd0, 17'sd0);
        send_item(fthgu_pkg::MODE_LOOKUP, 1'b0, 6'd0, 6'd63, 17'sd12345);
        send_item(fthgu_pkg::MODE_CLEAR, 1'b1, 6'd42, 6'd21, -17'sd777);
        send_item(fthgu_pkg::MODE_LOOKUP, 1'b1, 6'd63, 6'd63, 17'sd0);
        drain();
        // zero divisor, saturation both ways, new fill leaves entries alone
        configure(-5000, 0);
        send_item(fthgu_pkg::MODE_UPDATE, 1'b1, 6'd5, 6'd5, 17'sd65535);
        send_item(fthgu_pkg::MODE_UPDATE, 1'b1, 6'd5, 6'd5, 17'sd65535);
        send_item(fthgu_pkg::MODE_LOOKUP, 1'b1, 6'd5, 6'd5, 17'sd0);
        repeat (4) send_item(fthgu_pkg::MODE_UPDATE, 1'b1, 6'd5, 6'd5, -17'sd65536);
        send_item(fthgu_pkg::MODE_LOOKUP, 1'b0, 6'd63, 6'd0, 17'sd0);
        send_item(fthgu_pkg::MODE_CLEAR, 1'b0, 6'd0, 6'd0, 17'sd0);
        send_item(fthgu_pkg::MODE_LOOKUP, 1'b1, 6'd5, 6'd5, 17'sd0);
        drain();
        configure(8191, 1);
        send_item(fthgu_pkg::MODE_UPDATE, 1'b0, 6'd9, 6'd9, 17'sd65535);
        send_item(fthgu_pkg::MODE_UPDATE, 1'b0, 6'd9, 6'd9, -17'sd65536);
        send_item(fthgu_pkg::MODE_UPDATE, 1'b0, 6'd9, 6'd9, 17'sd1);

        for (int p = 0; p < 6; p++) begin
            drain();
            if (p == 4) begin
                fill_list[p]    = int'($urandom_range(0, 10000)) - 5000;
                divisor_list[p] = $urandom_range(1, 50000);
            end
            configure(fill_list[p], divisor_list[p]);
            no_gaps = (p % 3 == 1);
            if (p == 2) hold_pending = 1'b1;
            foreach (hot[k]) hot[k] = 13'($urandom);
            // mostly repeated hits on a few entries so scores climb toward the
            // gravity limit; the rest lands anywhere
            repeat (PHASE_ITEMS) begin
                pick  = $urandom_range(0, 99);
                entry = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 7)]
                                                    : 13'($urandom);
                case ($urandom_range(0, 9))
                    0:       bonus_val = $urandom_range(0, 1) ? 65535 : -65536;
                    1, 2, 3: bonus_val = int'($urandom_range(0, 400)) - 200;
                    default: bonus_val = int'($urandom_range(0, 100000)) - 50000;
                endcase
                if (pick < 2)       mode = fthgu_pkg::MODE_CLEAR;
                else if (pick < 6)  mode = MODE_SPARE;
                else if (pick < 40) mode = fthgu_pkg::MODE_LOOKUP;
                else                mode = fthgu_pkg::MODE_UPDATE;
                send_item(mode, entry[12], entry[11:6], entry[5:0],
                          fthgu_pkg::BONUS_W'(bonus_val));
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
